// File: rtl/mfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared sizes, payload types and control structs of the feedback queue
// scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

    localparam int NUM_LEVELS   = 10;
    localparam int QUEUE_DEPTH  = 64;
    localparam int SERVICE_BITS = 16;

    localparam int LVL_W     = $clog2(NUM_LEVELS);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SLICE_W   = NUM_LEVELS;
    localparam int JOB_W     = 8 + SERVICE_BITS;

    typedef struct packed {
        logic        arrival_valid;
        logic [7:0]  arrival_id;
        logic [15:0] arrival_service;
    } mfq_in_t;

    typedef struct packed {
        logic        busy_res;
        logic [7:0]  served_id;
        logic [15:0] served_remaining;
        logic [3:0]  served_level;
        logic        all_empty;
        logic        arrival_dropped;
        logic        demote_dropped;
    } mfq_out_t;

    typedef struct packed {
        logic [7:0]              id;
        logic [SERVICE_BITS-1:0] remaining;
    } job_t;

    typedef struct packed {
        logic             enq;
        logic             deq;
        logic [LVL_W-1:0] level;
    } ptr_cmd_t;

    typedef struct packed {
        logic             full;
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic             any;
        logic [LVL_W-1:0] first;
    } ptr_stat_t;

endpackage
`default_nettype wire

// File: rtl/multilevel_feedback_queue_scheduler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top
// Feedback queue scheduler: one input transfer per tick, one result per tick.
// ----------------------------------------------------------------------------
// Each input transfer is one scheduler tick and yields exactly one result
// transfer. A tick steps through the states S_IDLE, S_DEMOTE, S_PICK and
// S_SERVE, with S_LOAD before S_SERVE when a new job is taken from a queue,
// and its result is loaded into the output register in S_SERVE. The order
// is set by the single write and single read port of the job memory, which
// the tick uses in turn for the arrival write, the demotion write and the
// dequeue read, followed by the service step. The result sits in an output
// register, so the next tick is accepted while it waits; a result still
// waiting holds the next tick in its service step. The job memory needs no
// clearing after reset; the block accepts input as soon as reset is released.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_top
    import mfq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire mfq_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output mfq_out_t      out_data
);

    ptr_cmd_t          ptr_cmd;
    ptr_stat_t         ptr_stat;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    job_t              mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    job_t              mem_rdata;
    logic              idle;
    logic              in_fire;
    logic              out_free;
    logic              res_load;
    mfq_out_t          res;
    logic              out_valid_reg;
    mfq_out_t          out_data_reg;

    assign in_ready  = idle;
    assign in_fire   = in_valid && idle;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    mfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_data   (in_data),
        .idle      (idle),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .ptr_cmd   (ptr_cmd),
        .ptr_stat  (ptr_stat),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    mfq_ptrs u_ptrs (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ptr_cmd),
        .stat  (ptr_stat)
    );

    mfq_store #(
        .DATA_W (JOB_W),
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= res;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mfq_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfq_store
// Generic simple dual-port RAM: one write port and one registered read port.
// ----------------------------------------------------------------------------
module mfq_store #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 640,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/mfq_ptrs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfq_ptrs
// Head, tail and fill count of every level queue, with the search for the
// lowest non-empty level.
// ----------------------------------------------------------------------------
module mfq_ptrs
    import mfq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ptr_cmd_t  cmd,
    output ptr_stat_t      stat
);

    logic [PTR_W-1:0] head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] tail_reg  [NUM_LEVELS];
    logic [CNT_W-1:0] count_reg [NUM_LEVELS];
    logic [PTR_W-1:0] head_next [NUM_LEVELS];
    logic [PTR_W-1:0] tail_next [NUM_LEVELS];
    logic [CNT_W-1:0] count_next[NUM_LEVELS];

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        wrap_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        stat.full  = (count_reg[cmd.level] >= CNT_W'(QUEUE_DEPTH));
        stat.head  = head_reg[cmd.level];
        stat.tail  = tail_reg[cmd.level];
        stat.any   = 1'b0;
        stat.first = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                stat.any   = 1'b1;
                stat.first = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
            if (cmd.level == LVL_W'(i))
            begin
                if (cmd.enq && (count_reg[i] < CNT_W'(QUEUE_DEPTH)))
                begin
                    tail_next[i]  = wrap_next(tail_reg[i]);
                    count_next[i] = count_reg[i] + 1'b1;
                end
                else if (cmd.deq && (count_reg[i] != '0))
                begin
                    head_next[i]  = wrap_next(head_reg[i]);
                    count_next[i] = count_reg[i] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/mfq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfq_ctrl
// Tick sequencer: arrival write, retire or demotion write, dequeue read,
// job load and service, at most one memory access per cycle.
// ----------------------------------------------------------------------------
module mfq_ctrl
    import mfq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire mfq_in_t           in_data,
    output logic                   idle,
    input  wire logic              out_free,
    output logic                   res_load,
    output mfq_out_t               res,
    output ptr_cmd_t               ptr_cmd,
    input  wire ptr_stat_t         ptr_stat,
    output logic                   mem_we,
    output logic      [ADDR_W-1:0] mem_waddr,
    output job_t                   mem_wdata,
    output logic                   mem_re,
    output logic      [ADDR_W-1:0] mem_raddr,
    input  wire job_t              mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEMOTE,
        S_PICK,
        S_LOAD,
        S_SERVE
    } state_t;

    state_t                  state_reg;
    logic [7:0]              cur_id_reg;
    logic [SERVICE_BITS-1:0] cur_rem_reg;
    logic [LVL_W-1:0]        cur_lvl_reg;
    logic [SLICE_W-1:0]      slice_reg;
    logic                    running_reg;
    logic                    arr_drop_reg;
    logic                    dem_drop_reg;

    logic [LVL_W-1:0]        target;
    logic [SLICE_W-1:0]      slice_len;
    logic                    slice_done;
    logic                    rem_zero;
    logic                    demote;
    logic [SERVICE_BITS-1:0] rem_after;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [PTR_W-1:0] ptr);
        mem_addr = ADDR_W'(int'(lvl) * QUEUE_DEPTH + int'(ptr));
    endfunction

    assign target     = (cur_lvl_reg == LVL_W'(NUM_LEVELS - 1)) ? cur_lvl_reg
                                                               : cur_lvl_reg + 1'b1;
    assign slice_len  = SLICE_W'(1) << cur_lvl_reg;
    assign slice_done = (slice_reg >= slice_len);
    assign rem_zero   = (cur_rem_reg == '0);
    assign demote     = running_reg && !rem_zero && slice_done;
    assign rem_after  = (running_reg && !rem_zero) ? cur_rem_reg - 1'b1 : cur_rem_reg;
    assign idle       = (state_reg == S_IDLE);
    assign res_load   = (state_reg == S_SERVE) && out_free;

    always_comb
    begin
        ptr_cmd   = '0;
        mem_we    = 1'b0;
        mem_waddr = mem_addr(ptr_cmd.level, ptr_stat.tail);
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = mem_addr(ptr_cmd.level, ptr_stat.head);
        unique case (state_reg)
            S_IDLE:
            begin
                ptr_cmd.level = '0;
                ptr_cmd.enq   = in_fire && in_data.arrival_valid;
                mem_we        = ptr_cmd.enq && !ptr_stat.full;
                mem_waddr     = mem_addr('0, ptr_stat.tail);
                mem_wdata.id  = in_data.arrival_id;
                mem_wdata.remaining = SERVICE_BITS'(in_data.arrival_service);
            end
            S_DEMOTE:
            begin
                ptr_cmd.level = target;
                ptr_cmd.enq   = demote;
                mem_we        = demote && !ptr_stat.full;
                mem_waddr     = mem_addr(target, ptr_stat.tail);
                mem_wdata.id  = cur_id_reg;
                mem_wdata.remaining = cur_rem_reg;
            end
            S_PICK:
            begin
                ptr_cmd.level = ptr_stat.first;
                ptr_cmd.deq   = !running_reg && ptr_stat.any;
                mem_re        = ptr_cmd.deq;
                mem_raddr     = mem_addr(ptr_stat.first, ptr_stat.head);
            end
            S_LOAD, S_SERVE:
            begin
                ptr_cmd = '0;
            end
            default:
            begin
                ptr_cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        res.busy_res         = running_reg;
        res.served_id        = running_reg ? cur_id_reg : '0;
        res.served_remaining = running_reg ? 16'(rem_after) : '0;
        res.served_level     = running_reg ? 4'(cur_lvl_reg) : '0;
        res.all_empty        = (!running_reg || (rem_after == '0)) && !ptr_stat.any;
        res.arrival_dropped  = arr_drop_reg;
        res.demote_dropped   = dem_drop_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_id_reg   <= '0;
            cur_rem_reg  <= '0;
            cur_lvl_reg  <= '0;
            slice_reg    <= '0;
            running_reg  <= 1'b0;
            arr_drop_reg <= 1'b0;
            dem_drop_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        arr_drop_reg <= in_data.arrival_valid && ptr_stat.full;
                        dem_drop_reg <= 1'b0;
                        state_reg    <= S_DEMOTE;
                    end
                end
                S_DEMOTE:
                begin
                    if (running_reg && (rem_zero || slice_done))
                    begin
                        running_reg <= 1'b0;
                        slice_reg   <= '0;
                    end
                    if (demote)
                    begin
                        dem_drop_reg <= ptr_stat.full;
                    end
                    state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    if (!running_reg && ptr_stat.any)
                    begin
                        cur_lvl_reg <= ptr_stat.first;
                        state_reg   <= S_LOAD;
                    end
                    else
                    begin
                        state_reg <= S_SERVE;
                    end
                end
                S_LOAD:
                begin
                    cur_id_reg  <= mem_rdata.id;
                    cur_rem_reg <= mem_rdata.remaining;
                    slice_reg   <= '0;
                    running_reg <= 1'b1;
                    state_reg   <= S_SERVE;
                end
                S_SERVE:
                begin
                    if (out_free)
                    begin
                        if (running_reg && !rem_zero)
                        begin
                            cur_rem_reg <= rem_after;
                            slice_reg   <= slice_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: dv/mfq_sched_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfq_sched_checker
// Watches the tick and result channels of the feedback queue scheduler. It
// keeps its own copy of the level queues and the running job, works out the
// result of every accepted tick, and compares results in order, field by field.
// ----------------------------------------------------------------------------
module mfq_sched_checker
    import mfq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  mfq_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  mfq_out_t out_data,
    output int       error_count,
    output int       pending_count,
    output int       checked_count,
    output int       arrival_drops,
    output int       demote_drops,
    output int       last_level_hits
);

    job_t                    lvl_jobs  [NUM_LEVELS][QUEUE_DEPTH];
    int unsigned             lvl_head  [NUM_LEVELS];
    int unsigned             lvl_tail  [NUM_LEVELS];
    int unsigned             lvl_count [NUM_LEVELS];
    logic [7:0]              cur_id;
    logic [SERVICE_BITS-1:0] cur_left;
    int unsigned             cur_level;
    int unsigned             cur_used;
    bit                      cur_active;

    mfq_out_t                due_results [$];
    int                      errs;
    int                      n_checked;
    int                      n_arr_drop;
    int                      n_dem_drop;
    int                      n_last;

    function automatic int unsigned step_ptr(int unsigned p);
        return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic bit level_push(int unsigned lvl, logic [7:0] id,
                                      logic [SERVICE_BITS-1:0] left);
        if (lvl_count[lvl] >= QUEUE_DEPTH)
            return 1'b0;
        lvl_jobs[lvl][lvl_tail[lvl]].id        = id;
        lvl_jobs[lvl][lvl_tail[lvl]].remaining = left;
        lvl_tail[lvl]  = step_ptr(lvl_tail[lvl]);
        lvl_count[lvl] = lvl_count[lvl] + 1;
        return 1'b1;
    endfunction

    function automatic mfq_out_t schedule_tick(mfq_in_t t);
        mfq_out_t    r;
        int unsigned target;
        int unsigned lvl;
        r = '0;
        if (t.arrival_valid && !level_push(0, t.arrival_id, t.arrival_service))
            r.arrival_dropped = 1'b1;

        if (cur_active) begin
            if (cur_left == 0) begin
                cur_active = 1'b0;
                cur_used   = 0;
            end
            else if (cur_used >= (32'd1 << cur_level)) begin
                target = (cur_level + 1 >= NUM_LEVELS) ? NUM_LEVELS - 1 : cur_level + 1;
                if (!level_push(target, cur_id, cur_left))
                    r.demote_dropped = 1'b1;
                cur_active = 1'b0;
                cur_used   = 0;
            end
        end

        if (!cur_active) begin
            for (lvl = 0; lvl < NUM_LEVELS; lvl++) begin
                if (!cur_active && lvl_count[lvl] != 0) begin
                    cur_id         = lvl_jobs[lvl][lvl_head[lvl]].id;
                    cur_left       = lvl_jobs[lvl][lvl_head[lvl]].remaining;
                    lvl_head[lvl]  = step_ptr(lvl_head[lvl]);
                    lvl_count[lvl] = lvl_count[lvl] - 1;
                    cur_level      = lvl;
                    cur_used       = 0;
                    cur_active     = 1'b1;
                end
            end
        end

        if (cur_active) begin
            if (cur_left != 0 && cur_used < (32'd1 << cur_level)) begin
                cur_left = cur_left - 1'b1;
                cur_used = cur_used + 1;
            end
            r.busy_res         = 1'b1;
            r.served_id        = cur_id;
            r.served_remaining = cur_left;
            r.served_level     = cur_level[3:0];
        end

        r.all_empty = !cur_active || cur_left == 0;
        for (lvl = 0; lvl < NUM_LEVELS; lvl++)
            if (lvl_count[lvl] != 0)
                r.all_empty = 1'b0;
        return r;
    endfunction

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            errs++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        mfq_out_t want;
        if (!rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                lvl_head[l]  = 0;
                lvl_tail[l]  = 0;
                lvl_count[l] = 0;
            end
            cur_id     = '0;
            cur_left   = '0;
            cur_level  = 0;
            cur_used   = 0;
            cur_active = 1'b0;
            due_results.delete();
            errs       = 0;
            n_checked  = 0;
            n_arr_drop = 0;
            n_dem_drop = 0;
            n_last     = 0;
        end
        else begin
            if (in_valid && in_ready)
                due_results.push_back(schedule_tick(in_data));
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    errs++;
                    $display("%0t: result transfer with no tick outstanding, expected none, actual %h",
                             $time, out_data);
                end
                else begin
                    want = due_results.pop_front();
                    check_field("busy_res", want.busy_res, out_data.busy_res);
                    check_field("served_id", want.served_id, out_data.served_id);
                    check_field("served_remaining", want.served_remaining,
                                out_data.served_remaining);
                    check_field("served_level", want.served_level, out_data.served_level);
                    check_field("all_empty", want.all_empty, out_data.all_empty);
                    check_field("arrival_dropped", want.arrival_dropped,
                                out_data.arrival_dropped);
                    check_field("demote_dropped", want.demote_dropped, out_data.demote_dropped);
                    n_checked++;
                    n_arr_drop += want.arrival_dropped;
                    n_dem_drop += want.demote_dropped;
                    if (want.busy_res && want.served_level == NUM_LEVELS - 1)
                        n_last++;
                end
            end
        end
        error_count     <= errs;
        pending_count   <= due_results.size();
        checked_count   <= n_checked;
        arrival_drops   <= n_arr_drop;
        demote_drops    <= n_dem_drop;
        last_level_hits <= n_last;
    end

endmodule

// File: dv/tb_multilevel_feedback_queue_scheduler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_queue_scheduler_top
// Drives scheduler ticks with random idling on both channels: a few directed
// ticks, a mixed workload, an arrival flood that fills level 1, and a long
// job that sinks to the last level while bursts overflow level 0.
// ----------------------------------------------------------------------------
module tb_multilevel_feedback_queue_scheduler_top;
    import mfq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 37;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    mfq_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    mfq_out_t out_data;

    int       error_count;
    int       pending_count;
    int       checked_count;
    int       arrival_drops;
    int       demote_drops;
    int       last_level_hits;
    int       ticks_sent;
    int       cycles;
    bit       steady;

    multilevel_feedback_queue_scheduler_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    mfq_sched_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .error_count     (error_count),
        .pending_count   (pending_count),
        .checked_count   (checked_count),
        .arrival_drops   (arrival_drops),
        .demote_drops    (demote_drops),
        .last_level_hits (last_level_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycles, pending_count);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_tick(input logic av, input logic [7:0] id, input logic [15:0] svc);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{arrival_valid: av, arrival_id: id, arrival_service: svc};
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    task automatic send_mix(input int n, input int arrive_pct, input int svc_max);
        logic        av;
        logic [15:0] svc;
        for (int k = 0; k < n; k++)
        begin
            av  = ($urandom_range(99) < arrive_pct);
            svc = ($urandom_range(7) == 0) ? 16'($urandom_range(40))
                                           : 16'($urandom_range(svc_max));
            send_tick(av, 8'($urandom), av ? svc : 16'($urandom));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        steady      = 1'b0;
        ticks_sent  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle, zero service, id extremes, short demotions
        send_tick(1'b0, 8'hFF, 16'hFFFF);
        send_tick(1'b1, 8'h00, 16'h0000);
        send_tick(1'b0, 8'h00, 16'h0000);
        send_tick(1'b1, 8'hFF, 16'h0001);
        send_tick(1'b1, 8'h01, 16'h0002);
        send_tick(1'b1, 8'h02, 16'h0003);
        send_tick(1'b1, 8'h80, 16'h0004);
        send_tick(1'b1, 8'h03, 16'h0000);
        send_tick(1'b1, 8'h04, 16'h0000);
        repeat (10) send_tick(1'b0, 8'($urandom), 16'($urandom));
        wait_drained();

        send_mix(150, 50, 6);

        // flood level 0 every tick so demotions overflow level 1
        steady = 1'b1;
        repeat (80) send_tick(1'b1, 8'($urandom), 16'($urandom_range(5, 2)));
        steady = 1'b0;
        wait_drained();

        // long job sinks to the last level; bursts overflow level 0 meanwhile
        send_tick(1'b1, 8'hFF, 16'hFFFF);
        for (int i = 0; i < 1100; i++)
        begin
            if (i % 400 >= 330)
                send_tick(1'b1, 8'($urandom), 16'($urandom_range(1)));
            else
                send_mix(1, 10, 3);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d ticks, checked %0d results, %0d failures found.",
                 ticks_sent, checked_count, error_count);
        $display("Arrival drops %0d, demotion drops %0d, busy ticks at the last level %0d.",
                 arrival_drops, demote_drops, last_level_hits);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
